>>> src/gba_pkg.sv
// Shared types and constants for the growable bitmap allocator.
// Holds command and status codes, field widths and the growth status struct.
// No dependencies.
package gba_pkg;

    localparam int CMD_W    = 3;
    localparam int BIT_W    = 12;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 11;
    localparam int ACTB_W   = 12;

    localparam int CAPACITY_BYTES_DEF = 256;
    localparam int INITIAL_BYTES_DEF  = 8;

    localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEST    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_ALL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NORES    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPARAM = 2'd2;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    // growth unit handshake back to the sequencer
    typedef struct packed {
        logic done;
        logic nores;
    } grow_stat_t;

endpackage

>>> src/gba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/gba_grow.sv
// Growth size unit: finds the smallest multiple of the active size above the
// needed byte count, one add and compare per cycle. Depends on gba_pkg.
module gba_grow #(
    parameter int CAP = 256,
    parameter int AW  = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [AW-1:0]       need,
    input  logic [AW-1:0]       active,
    output gba_pkg::grow_stat_t stat,
    output logic [AW-1:0]       size
);
    import gba_pkg::*;

    localparam logic [AW-1:0] CAP_V = AW'(CAP);

    logic          busy_reg, busy_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] need_reg, need_next;
    logic [AW-1:0] step_reg, step_next;
    logic          over_cap;
    logic          covers;

    assign over_cap   = acc_reg > CAP_V;
    assign covers     = acc_reg > need_reg;
    assign stat.done  = busy_reg && (over_cap || covers);
    assign stat.nores = over_cap;
    assign size       = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        acc_next  = acc_reg;
        need_next = need_reg;
        step_next = step_reg;
        if (go)
        begin
            // caller only starts when need >= active, so the first multiple
            // worth testing is active itself
            busy_next = 1'b1;
            acc_next  = active;
            need_next = need;
            step_next = active;
        end
        else if (busy_reg)
        begin
            if (over_cap || covers)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                acc_next = acc_reg + step_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        need_reg <= need_next;
        step_reg <= step_next;
    end

endmodule

>>> src/growable_bitmap_allocator.sv
// Growable bitmap allocator top level: command sequencer around the byte store.
// Depends on gba_pkg, gba_ram (byte store) and gba_grow (growth size unit).
//
//  channel   | signals                               | transfer
//  ----------+---------------------------------------+----------------------------
//  command   | start, cmd, bit_req  -> busy          | edge with start & !busy
//  result    | done, status, is_set, position,       | edge ending the done cycle
//            | active_bits                           |
//
// Test and set/clear pass through a read state and a read-modify-write state;
// clear all / set all write each active byte, and find reads the active bytes
// (one byte read per cycle). Growth runs the add/compare loop, then zero fills
// each new byte; a find that met a full store then sets its bit in S_RD/S_RMW.
// Bad test parameters and unknown commands answer straight from idle. After reset
// the first INITIAL_BYTES bytes (capped at CAPACITY_BYTES) are swept to zero, one
// a cycle, with busy high. done is a one-cycle strobe the receiver cannot stall.
module growable_bitmap_allocator #(
    parameter int CAPACITY_BYTES = gba_pkg::CAPACITY_BYTES_DEF,
    parameter int INITIAL_BYTES  = gba_pkg::INITIAL_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [gba_pkg::CMD_W-1:0]    cmd,
    input  logic [gba_pkg::BIT_W-1:0]    bit_req,
    output logic                         done,
    output logic [gba_pkg::STATUS_W-1:0] status,
    output logic                         is_set,
    output logic [gba_pkg::POS_W-1:0]    position,
    output logic [gba_pkg::ACTB_W-1:0]   active_bits
);
    import gba_pkg::*;

    // byte counts up to 2*capacity, and at least the 512 a 12-bit bit number needs
    localparam int AW_CAP   = $clog2(2 * CAPACITY_BYTES + 1);
    localparam int AW       = (AW_CAP > 10) ? AW_CAP : 10;
    localparam int IW       = $clog2(CAPACITY_BYTES);
    localparam int INIT_ACT = (INITIAL_BYTES > CAPACITY_BYTES) ? CAPACITY_BYTES
                                                               : INITIAL_BYTES;
    localparam logic [AW-1:0] INIT_ACT_V = AW'(INIT_ACT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_GROW  = 3'd2;
    localparam logic [2:0] S_ZFILL = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_RMW   = 3'd5;
    localparam logic [2:0] S_FILL  = 3'd6;
    localparam logic [2:0] S_SCAN  = 3'd7;

    function automatic logic [2:0] lowest_zero(input logic [7:0] v);
        logic [2:0] b;
        b = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!v[k])
            begin
                b = 3'(k);
            end
        end
        return b;
    endfunction

    // sequencer state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] active_reg, active_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] size_reg, size_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic [2:0]    bitpos_reg, bitpos_next;
    logic [2:0]    op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // result registers
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                is_set_reg, is_set_next;
    logic [POS_W-1:0]    position_reg, position_next;

    // byte store ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // growth unit
    logic          grow_go;
    logic [AW-1:0] grow_need;
    grow_stat_t    grow_stat;
    logic [AW-1:0] grow_size;

    logic          accept;
    logic [AW-1:0] req_byte;
    logic [AW-1:0] req_need;
    logic [AW+2:0] act_bits_full;
    logic [AW+2:0] bit_ext;
    logic          test_bad;
    logic [2:0]    zero_pos;
    logic [AW+2:0] found_pos;
    logic [AW+2:0] tail_pos;
    logic [7:0]    bit_mask;

    assign accept        = start && !busy;
    assign busy          = state_reg != S_IDLE;
    assign req_byte      = AW'(bit_req[BIT_W-1:3]);
    // bit_req divided by eight, rounded up, in bytes
    assign req_need      = req_byte + AW'(|bit_req[2:0]);
    assign act_bits_full = {active_reg, 3'b000};
    assign bit_ext       = (AW+3)'(bit_req);
    assign test_bad      = bit_ext >= act_bits_full;
    assign zero_pos      = lowest_zero(ram_rdata);
    assign found_pos     = {chk_idx_reg, zero_pos};
    assign tail_pos      = {active_reg, 3'b000};
    assign bit_mask      = 8'(1) << bitpos_reg;
    assign grow_need     = (state_reg == S_SCAN) ? active_reg : req_need;

    assign done        = done_reg;
    assign status      = status_reg;
    assign is_set      = is_set_reg;
    assign position    = position_reg;
    assign active_bits = act_bits_full[ACTB_W-1:0];

    gba_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gba_grow #(
        .CAP (CAPACITY_BYTES),
        .AW  (AW)
    ) u_grow (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (grow_go),
        .need   (grow_need),
        .active (active_reg),
        .stat   (grow_stat),
        .size   (grow_size)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        sweep_next     = sweep_reg;
        scan_next      = scan_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        size_next      = size_reg;
        tgt_next       = tgt_reg;
        bitpos_next    = bitpos_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        is_set_next    = is_set_reg;
        position_next  = position_reg;
        grow_go        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg[IW-1:0];
        ram_wdata      = BYTE_EMPTY;
        ram_raddr      = tgt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = cmd;
                    tgt_next      = req_byte[IW-1:0];
                    bitpos_next   = bit_req[2:0];
                    status_next   = ST_OK;
                    is_set_next   = 1'b0;
                    position_next = '0;
                    unique case (cmd)
                        CMD_SET, CMD_CLEAR:
                        begin
                            if (req_need >= active_reg)
                            begin
                                grow_go    = 1'b1;
                                state_next = S_GROW;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        CMD_TEST:
                        begin
                            if (test_bad)
                            begin
                                status_next = ST_BADPARAM;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        CMD_CLR_ALL, CMD_SET_ALL:
                        begin
                            sweep_next = '0;
                            state_next = S_FILL;
                        end
                        CMD_FIND:
                        begin
                            scan_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            status_next = ST_BADPARAM;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                ram_we = 1'b1;
                if (sweep_reg == INIT_ACT_V - AW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_GROW:
            begin
                if (grow_stat.done)
                begin
                    if (grow_stat.nores)
                    begin
                        // nothing changes; a failed find reports position 0
                        status_next = ST_NORES;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        size_next  = grow_size;
                        sweep_next = active_reg;
                        state_next = S_ZFILL;
                    end
                end
            end

            S_ZFILL:
            begin
                // new bytes were never written since reset: zero them
                ram_we = 1'b1;
                if (sweep_reg == size_reg - AW'(1))
                begin
                    active_next = size_reg;
                    state_next  = S_RD;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_RD:
            begin
                state_next = S_RMW;
            end

            S_RMW:
            begin
                ram_waddr  = tgt_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (op_reg == CMD_TEST)
                begin
                    is_set_next = ram_rdata[bitpos_reg];
                end
                else
                begin
                    ram_we = 1'b1;
                    if (op_reg == CMD_CLEAR)
                    begin
                        ram_wdata = ram_rdata & ~bit_mask;
                    end
                    else
                    begin
                        ram_wdata = ram_rdata | bit_mask;
                    end
                    if (op_reg == CMD_FIND)
                    begin
                        position_next = pos_reg;
                    end
                end
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = (op_reg == CMD_SET_ALL) ? BYTE_FULL : BYTE_EMPTY;
                if (sweep_reg == active_reg - AW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end

            S_SCAN:
            begin
                // read issued at scan_reg, checked in the following cycle at chk_idx_reg
                ram_raddr      = scan_reg[IW-1:0];
                chk_valid_next = scan_reg < active_reg;
                chk_idx_next   = scan_reg;
                if (scan_reg < active_reg)
                begin
                    scan_next = scan_reg + AW'(1);
                end
                if (chk_valid_reg && (ram_rdata != BYTE_FULL))
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = chk_idx_reg[IW-1:0];
                    ram_wdata     = ram_rdata | (8'(1) << zero_pos);
                    position_next = found_pos[POS_W-1:0];
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (!chk_valid_reg && (scan_reg == active_reg))
                begin
                    // store full: allocate the first bit past the active size
                    tgt_next    = active_reg[IW-1:0];
                    bitpos_next = 3'd0;
                    pos_next    = tail_pos[POS_W-1:0];
                    grow_go     = 1'b1;
                    state_next  = S_GROW;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            active_reg    <= INIT_ACT_V;
            sweep_reg     <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            sweep_reg     <= sweep_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        size_reg     <= size_next;
        tgt_reg      <= tgt_next;
        bitpos_reg   <= bitpos_next;
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        is_set_reg   <= is_set_next;
        position_reg <= position_next;
    end

    // a multi-cycle command always ends with its result strobe;
    // the reset sweep ends without one
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy) && ($past(state_reg) != S_INIT)) |-> done)
        else $error("busy dropped without a result");

    // active size only grows and never passes capacity
    a_grow_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg >= $past(active_reg)) && (active_reg <= AW'(CAPACITY_BYTES)))
        else $error("active size shrank or exceeded capacity");

    // outside the reset clear and zero fill, only active bytes are written
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != S_INIT) && (state_reg != S_ZFILL))
            |-> (AW'(ram_waddr) < active_reg))
        else $error("write outside active bytes");

    // growth unit only answers while the sequencer waits on it
    a_grow_done: assert property (@(posedge clk) disable iff (!rst_n)
        grow_stat.done |-> (state_reg == S_GROW))
        else $error("growth result outside growth phase");

endmodule
